[rtl/first_fit_extent_allocator_macros.svh]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_macros
// Assertion macros for the extent allocator. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// plain property, checked at every rising edge outside reset
`define FFEA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("ffea: assertion failed");

// implication form: cons must hold whenever ante holds
`define FFEA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ffea: implication failed");

`else

`define FFEA_ASSERT(lbl, clk, rstn, prop)
`define FFEA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/ffea_pkg.sv]
// ----------------------------------------------------------------------------
// ffea_pkg
// Types, codes and helpers shared by the extent allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffea_pkg;

	localparam int SLOTS_DEF = 32;

	localparam logic [3:0] BLOCK_SHIFT_RST = 4'd9;

	// operation codes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_GROW   = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNUSED = 2'd1;
	localparam logic [1:0] ST_NOFREE = 2'd2;
	localparam logic [1:0] ST_NORUN  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_DATA_START  = 2'd0;
	localparam logic [1:0] CFG_DATA_BLOCKS = 2'd1;
	localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  slot;
		logic [31:0] size_bytes;
	} ffea_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot_out;
		logic [31:0] run_start;
		logic [31:0] run_length;
		logic [31:0] free_count;
	} ffea_res_t;

	typedef struct packed {
		logic [31:0] data_start;
		logic [31:0] data_blocks;
		logic [3:0]  block_shift;
	} ffea_cfg_t;

	typedef struct packed {
		logic wr_en;
		logic used_set;
		logic used_clr;
	} ffea_tbl_cmd_t;

	// bytes to blocks, rounding up; zero bytes still takes one block
	function automatic logic [31:0] size_to_blocks(input logic [31:0] bytes,
			input logic [3:0] sh);
		logic [31:0] n;
		logic [31:0] mask;
		n    = bytes >> sh;
		mask = (32'd1 << sh) - 32'd1;
		if (bytes == 32'd0) begin
			return 32'd1;
		end
		return n + {31'd0, |(bytes & mask)};
	endfunction

endpackage

`default_nettype wire

[rtl/first_fit_extent_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit allocator of contiguous block runs over a table of slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// word sits on result for exactly one cycle with done high and must be taken
// then, as there is no way to hold it off. Delete goes through the PREP, OLD
// and FIN states before done; no-op and requests on an unused slot go through
// PREP and FIN. Create and grow run first-fit passes; each pass reads every
// slot of the table through its one read port, one slot a cycle, then goes
// through DRAIN, LIMIT and EVAL; a request runs from 1 to SLOTS + 1 passes
// (grow adds the OLD state to read the old run). Used flags live in flops and
// are cleared by reset at once, so no clearing pass is needed. Configuration
// writes are always ready and must only be issued while busy is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_extent_allocator_macros.svh"

module first_fit_extent_allocator #(
	parameter int SLOTS = ffea_pkg::SLOTS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  ffea_pkg::ffea_cmd_t    cmd,
	output logic                   done,
	output ffea_pkg::ffea_res_t    result,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [1:0]             cfg_index,
	input  wire  [31:0]            cfg_data
);
	import ffea_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);

	ffea_cfg_t     cfg_q;
	ffea_tbl_cmd_t tbl_cmd;
	logic [IW-1:0] tbl_waddr;
	logic [31:0]   tbl_wstart;
	logic [31:0]   tbl_wblocks;
	logic [IW-1:0] tbl_raddr;
	logic [31:0]   tbl_rstart;
	logic [31:0]   tbl_rblocks;
	logic          tbl_rused;
	logic [IW-1:0] tbl_qaddr;
	logic          tbl_qused;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_start  <= 32'd0;
			cfg_q.data_blocks <= 32'd0;
			cfg_q.block_shift <= BLOCK_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DATA_START:  cfg_q.data_start  <= cfg_data;
				CFG_DATA_BLOCKS: cfg_q.data_blocks <= cfg_data;
				CFG_BLOCK_SHIFT: cfg_q.block_shift <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ffea_seq #(
		.SLOTS (SLOTS),
		.IW    (IW),
		.PW    (PW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.tbl_cmd     (tbl_cmd),
		.tbl_waddr   (tbl_waddr),
		.tbl_wstart  (tbl_wstart),
		.tbl_wblocks (tbl_wblocks),
		.tbl_raddr   (tbl_raddr),
		.tbl_rstart  (tbl_rstart),
		.tbl_rblocks (tbl_rblocks),
		.tbl_rused   (tbl_rused),
		.tbl_qaddr   (tbl_qaddr),
		.tbl_qused   (tbl_qused)
	);

	ffea_slot_table #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.tbl_cmd (tbl_cmd),
		.waddr   (tbl_waddr),
		.wstart  (tbl_wstart),
		.wblocks (tbl_wblocks),
		.raddr   (tbl_raddr),
		.rstart  (tbl_rstart),
		.rblocks (tbl_rblocks),
		.rused   (tbl_rused),
		.qaddr   (tbl_qaddr),
		.qused   (tbl_qused)
	);

	// result word only appears once the sequencer is back to idle
	`FFEA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// an accepted word always starts work
	`FFEA_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	// one result word per request
	`FFEA_ASSERT(a_done_pulse, clk, arst_n, done |=> !done)
	// a create with no free slot reports no run
	`FFEA_ASSERT_IMPL(a_nofree_empty, clk, arst_n, done && (result.status == ST_NOFREE),
		(result.slot_out == 5'd0) && (result.run_length == 32'd0))

endmodule

`default_nettype wire

[rtl/ffea_slot_table.sv]
// ----------------------------------------------------------------------------
// ffea_slot_table
// Slot table: used flags in flops, start and length in a memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffea_slot_table #(
	parameter int SLOTS = 32,
	parameter int IW    = 5
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ffea_pkg::ffea_tbl_cmd_t      tbl_cmd,
	input  wire  [IW-1:0]                waddr,
	input  wire  [31:0]                  wstart,
	input  wire  [31:0]                  wblocks,
	input  wire  [IW-1:0]                raddr,
	output logic [31:0]                  rstart,
	output logic [31:0]                  rblocks,
	output logic                         rused,
	input  wire  [IW-1:0]                qaddr,
	output logic                         qused
);
	import ffea_pkg::*;

	logic [31:0] start_mem  [SLOTS];
	logic [31:0] blocks_mem [SLOTS];
	logic [SLOTS-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (tbl_cmd.used_set) begin
				used_q[waddr] <= 1'b1;
			end else if (tbl_cmd.used_clr) begin
				used_q[waddr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_cmd.wr_en) begin
			start_mem[waddr]  <= wstart;
			blocks_mem[waddr] <= wblocks;
		end
		rstart  <= start_mem[raddr];
		rblocks <= blocks_mem[raddr];
		rused   <= used_q[raddr];
	end

	assign qused = used_q[qaddr];

endmodule

`default_nettype wire

[rtl/ffea_seq.sv]
// ----------------------------------------------------------------------------
// ffea_seq
// Request sequencer with the compare datapath: decodes a request,
// runs first-fit passes over the slot table and builds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffea_seq #(
	parameter int SLOTS = 32,
	parameter int IW    = 5,
	parameter int PW    = 6
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ffea_pkg::ffea_cfg_t          cfg,
	input  wire                          start,
	input  ffea_pkg::ffea_cmd_t          cmd,
	output logic                         busy,
	output logic                         done,
	output ffea_pkg::ffea_res_t          result,
	output ffea_pkg::ffea_tbl_cmd_t      tbl_cmd,
	output logic [IW-1:0]                tbl_waddr,
	output logic [31:0]                  tbl_wstart,
	output logic [31:0]                  tbl_wblocks,
	output logic [IW-1:0]                tbl_raddr,
	input  wire  [31:0]                  tbl_rstart,
	input  wire  [31:0]                  tbl_rblocks,
	input  wire                          tbl_rused,
	output logic [IW-1:0]                tbl_qaddr,
	input  wire                          tbl_qused
);
	import ffea_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_OLD    = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_DRAIN  = 4'd4;
	localparam logic [3:0] S_LIMIT  = 4'd5;
	localparam logic [3:0] S_EVAL   = 4'd6;
	localparam logic [3:0] S_COMMIT = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	localparam logic [32:0] ADDR_TOP = {1'b1, 32'd0};

	logic [3:0]    state_q;
	logic [1:0]    mode_q;
	logic [4:0]    slot_q;
	logic [IW-1:0] slot_idx_q;
	logic [31:0]   need_q;
	logic [32:0]   cursor_q;
	logic [32:0]   end_q;
	logic [32:0]   nstart_q;
	logic [32:0]   nend_q;
	logic [32:0]   limit_q;
	logic          hit_q;
	logic [PW-1:0] pass_q;
	logic [IW-1:0] scan_idx_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [31:0]   old_start_q;
	logic [31:0]   old_blocks_q;
	logic [31:0]   owned_q;
	ffea_res_t     res_q;
	logic          done_q;

	logic [32:0] area_sum;
	logic [32:0] area_end;
	logic        slot_ok;
	logic [32:0] st_w;
	logic        take_w;
	logic [33:0] gap_w;
	logic        fit_w;

	assign area_sum = {1'b0, cfg.data_start} + {1'b0, cfg.data_blocks};
	assign area_end = area_sum[32] ? ADDR_TOP : area_sum;
	assign slot_ok  = ({27'd0, slot_q} < 32'(SLOTS));

	// compare unit: candidate test during scan, fit test at pass end
	assign st_w   = {1'b0, tbl_rstart};
	assign take_w = tbl_rused && (st_w >= cursor_q) && (!hit_q || (st_w < nstart_q));
	assign gap_w  = {1'b0, limit_q} - {1'b0, cursor_q};
	assign fit_w  = !gap_w[33] && (gap_w[32:0] >= {1'b0, need_q});

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		tbl_raddr        = (state_q == S_SCAN) ? scan_idx_q : slot_idx_q;
		tbl_qaddr        = slot_idx_q;
		tbl_waddr        = (mode_q == MODE_CREATE) ? free_idx_q : slot_idx_q;
		tbl_wstart       = cursor_q[31:0];
		tbl_wblocks      = need_q;
		tbl_cmd.wr_en    = (state_q == S_COMMIT);
		tbl_cmd.used_set = (state_q == S_COMMIT) && (mode_q == MODE_CREATE);
		tbl_cmd.used_clr = (state_q == S_OLD) && (mode_q == MODE_DELETE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			vld_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pass_q       <= '0;
			scan_idx_q   <= '0;
			owned_q      <= 32'd0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_SCAN);

			// returned table word from the previous scan address
			if (vld_s1) begin
				if (take_w) begin
					hit_q    <= 1'b1;
					nstart_q <= st_w;
					nend_q   <= st_w + {1'b0, tbl_rblocks};
				end
				if (!tbl_rused && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q     <= cmd.mode;
						slot_q     <= cmd.slot;
						slot_idx_q <= IW'(cmd.slot);
						need_q     <= size_to_blocks(cmd.size_bytes, cfg.block_shift);
						state_q    <= S_PREP;
					end
				end
				S_PREP: begin
					cursor_q     <= {1'b0, cfg.data_start};
					end_q        <= area_end;
					nstart_q     <= area_end;
					hit_q        <= 1'b0;
					pass_q       <= '0;
					scan_idx_q   <= '0;
					free_found_q <= 1'b0;
					case (mode_q)
						MODE_CREATE: begin
							state_q <= S_SCAN;
						end
						MODE_GROW, MODE_DELETE: begin
							if (slot_ok && tbl_qused) begin
								state_q <= S_OLD;
							end else begin
								res_q.status     <= ST_UNUSED;
								res_q.slot_out   <= slot_q;
								res_q.run_start  <= 32'd0;
								res_q.run_length <= 32'd0;
								state_q          <= S_FIN;
							end
						end
						default: begin
							res_q.status     <= ST_OK;
							res_q.slot_out   <= 5'd0;
							res_q.run_start  <= 32'd0;
							res_q.run_length <= 32'd0;
							state_q          <= S_FIN;
						end
					endcase
				end
				S_OLD: begin
					// registered read of the addressed slot lands here
					old_start_q  <= tbl_rstart;
					old_blocks_q <= tbl_rblocks;
					res_q.slot_out <= slot_q;
					if (mode_q == MODE_DELETE) begin
						owned_q          <= owned_q - tbl_rblocks;
						res_q.status     <= ST_OK;
						res_q.run_start  <= 32'd0;
						res_q.run_length <= 32'd0;
						state_q          <= S_FIN;
					end else if (need_q > tbl_rblocks) begin
						state_q <= S_SCAN;
					end else begin
						res_q.status     <= ST_OK;
						res_q.run_start  <= tbl_rstart;
						res_q.run_length <= tbl_rblocks;
						state_q          <= S_FIN;
					end
				end
				S_SCAN: begin
					idx_s1 <= scan_idx_q;
					if (scan_idx_q == IW'(SLOTS - 1)) begin
						scan_idx_q <= '0;
						state_q    <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_LIMIT;
				end
				S_LIMIT: begin
					limit_q <= (nstart_q < end_q) ? nstart_q : end_q;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if ((mode_q == MODE_CREATE) && !free_found_q) begin
						res_q.status     <= ST_NOFREE;
						res_q.slot_out   <= 5'd0;
						res_q.run_start  <= 32'd0;
						res_q.run_length <= 32'd0;
						state_q          <= S_FIN;
					end else if (fit_w) begin
						state_q <= S_COMMIT;
					end else if (!hit_q || (nend_q >= end_q) || (pass_q == PW'(SLOTS))) begin
						res_q.status <= ST_NORUN;
						if (mode_q == MODE_CREATE) begin
							res_q.slot_out   <= 5'd0;
							res_q.run_start  <= 32'd0;
							res_q.run_length <= 32'd0;
						end else begin
							res_q.slot_out   <= slot_q;
							res_q.run_start  <= old_start_q;
							res_q.run_length <= old_blocks_q;
						end
						state_q <= S_FIN;
					end else begin
						// next pass starts at the end of the nearest run
						cursor_q <= nend_q;
						nstart_q <= end_q;
						hit_q    <= 1'b0;
						pass_q   <= pass_q + 1'b1;
						state_q  <= S_SCAN;
					end
				end
				S_COMMIT: begin
					res_q.status     <= ST_OK;
					res_q.run_start  <= cursor_q[31:0];
					res_q.run_length <= need_q;
					if (mode_q == MODE_CREATE) begin
						owned_q        <= owned_q + need_q;
						res_q.slot_out <= 5'(free_idx_q);
					end else begin
						owned_q        <= owned_q - old_blocks_q + need_q;
						res_q.slot_out <= slot_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q.free_count <= (owned_q > cfg.data_blocks) ? 32'd0 :
						cfg.data_blocks - owned_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
